// ===== rtl/lmsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsb_pkg
// Shared constants for the red/green LED matrix scan and bar display driver.
// ----------------------------------------------------------------------------
package lmsb_pkg;

   // default panel geometry
   localparam int DEF_PANEL_COLUMNS = 96;
   localparam int DEF_PANEL_LINES   = 64;
   localparam int DEF_SCAN_GROUPS   = 16;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_BAR   = 2'd1;
   localparam logic [1:0] OP_SWAP  = 2'd2;
   localparam logic [1:0] OP_SCAN  = 2'd3;

   // bar column: green rows from here to the bottom, red rows from the top to here
   localparam int BAR_GREEN_FIRST = 8;
   localparam int BAR_RED_LAST    = 23;

   localparam logic [7:0] DARK_BYTE = 8'hFF;

   localparam int LEVEL_W    = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

endpackage

// ===== rtl/lmsb_frame_mem.sv =====
// ----------------------------------------------------------------------------
// lmsb_frame_mem
// Frame store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lmsb_frame_mem #(
   parameter int DEPTH  = 3072,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [7:0]        rd_data_a,
   output logic [7:0]        rd_data_b
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/lmsb_addr_unit.sv =====
// ----------------------------------------------------------------------------
// lmsb_addr_unit
// Shared byte address generator and bar threshold compare.
// ----------------------------------------------------------------------------
module lmsb_addr_unit
   import lmsb_pkg::*;
#(
   parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
   parameter int PANEL_LINES   = DEF_PANEL_LINES,
   parameter int ADDR_W        = 12,
   parameter int LINE_W        = 6,
   parameter int BYTE_W        = 4
) (
   input  logic               bank_sel,
   input  logic               colour,
   input  logic [LINE_W-1:0]  line,
   input  logic [BYTE_W-1:0]  byte_idx,
   input  logic [LEVEL_W-1:0] level,
   output logic [ADDR_W-1:0]  addr,
   output logic               lit
);

   localparam int LINE_BYTES  = PANEL_COLUMNS / 8;
   localparam int PLANE_BYTES = PANEL_LINES * LINE_BYTES;
   localparam int THR_W       = LINE_W + 2;
   localparam int CMP_W       = (THR_W > LEVEL_W) ? THR_W : LEVEL_W;

   logic [1:0]       plane_idx;
   logic [THR_W-1:0] thr;

   assign plane_idx = {bank_sel, colour};
   assign addr      = ADDR_W'(int'(plane_idx) * PLANE_BYTES
                              + int'(line) * LINE_BYTES + int'(byte_idx));

   // threshold is 4 * (bottom line - line); bottom line is always lit
   assign thr = {LINE_W'(PANEL_LINES - 1) - line, 2'b00};
   assign lit = (line == LINE_W'(PANEL_LINES - 1)) || (CMP_W'(level) > CMP_W'(thr));

endmodule

// ===== rtl/led_matrix_scan_bar_display.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scan_bar_display
// Double-buffered red/green LED matrix driver with 1/SCAN_GROUPS multiplexing.
// ----------------------------------------------------------------------------
// Usage:
//  req_* takes one operation per transfer: pixel write or bar column into the
//  back buffer, swap request, or scan tick. The frame store is active low.
//  A scan tick returns PANEL_LINES/SCAN_GROUPS * PANEL_COLUMNS/8 transfers on
//  rsp_* (48 at the default size), rsp_tlast on the final one.
//  The shared address unit serves one memory access per cycle. A bar column
//  visits the red rows and then the green rows, and a scan tick returns one
//  pair per cycle while rsp_tready stays high.
//  req_tready is low while an operation runs; the next one is taken once the
//  read pipeline is empty. A finished pair waits in the output register while
//  the sequencer keeps one more pair in the memory read register.
//  A stalled receiver holds the scan sequencer, nothing is dropped.
//  Reset: a clearing pass writes all ones to all STORE_BYTES frame store bytes
//  (3072 at default size), with req_tready low.
// ----------------------------------------------------------------------------
module led_matrix_scan_bar_display
   import lmsb_pkg::*;
#(
   parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
   parameter int PANEL_LINES   = DEF_PANEL_LINES,
   parameter int SCAN_GROUPS   = DEF_SCAN_GROUPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] pixel_color, [7:1] column, [13:8] row, [14] pixel_on, [22:15] level
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] red_byte, [15:8] green_byte, [19:16] row_select
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int LINE_BYTES  = PANEL_COLUMNS / 8;
   localparam int PLANE_BYTES = PANEL_LINES * LINE_BYTES;
   localparam int STORE_BYTES = 4 * PLANE_BYTES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LINE_W      = $clog2(PANEL_LINES);
   localparam int BYTE_W      = $clog2(LINE_BYTES);
   localparam int SROW_W      = $clog2(SCAN_GROUPS);
   localparam int RED_LAST    = (BAR_RED_LAST < PANEL_LINES - 1) ? BAR_RED_LAST
                                                                 : PANEL_LINES - 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_PIXEL = 3'd2;
   localparam logic [2:0] ST_BAR   = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;

   // request fields
   logic               req_colour;
   logic [6:0]         req_column;
   logic [5:0]         req_row;
   logic               req_on;
   logic [LEVEL_W-1:0] req_level;
   logic               req_xfer;

   assign req_colour = req_tdata[0];
   assign req_column = req_tdata[7:1];
   assign req_row    = req_tdata[13:8];
   assign req_on     = req_tdata[14];
   assign req_level  = req_tdata[22:15];

   // control state
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              bank_ff, bank_in;
   logic [SROW_W-1:0] scan_row_ff, scan_row_in;
   logic              swap_ff, swap_in;
   logic              rd_pending_ff, rd_pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              wr_pending_ff, wr_pending_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              green_ff, green_in;

   // payload
   logic               item_colour_ff;
   logic [6:0]         item_column_ff;
   logic [5:0]         item_row_ff;
   logic               item_on_ff;
   logic [LEVEL_W-1:0] item_level_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [7:0]         wr_mask_ff;
   logic               wr_lit_ff;
   logic [3:0]         rd_row_ff;
   logic               rd_last_ff;
   logic [7:0]         rsp_red_ff;
   logic [7:0]         rsp_green_ff;
   logic [3:0]         rsp_row_ff;
   logic               rsp_last_ff;

   // shared unit and memory hookup
   logic               au_bank;
   logic               au_colour;
   logic [LINE_W-1:0]  au_line;
   logic [BYTE_W-1:0]  au_byte;
   logic [ADDR_W-1:0]  au_addr;
   logic               au_lit;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [7:0]         mem_wdata;
   logic               mem_re;
   logic [7:0]         rd_red;
   logic [7:0]         rd_green;
   logic               rmw_issue;
   logic               rmw_lit;
   logic               scan_issue;
   logic               scan_last;
   logic               load_out;
   logic               item_valid;
   logic               line_done;

   assign req_tready = (state_ff == ST_IDLE) && !rd_pending_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign load_out   = rd_pending_ff && (!rsp_valid_ff || rsp_tready);

   assign item_valid = (32'(item_column_ff) < PANEL_COLUMNS) &&
                       (32'(item_row_ff) < PANEL_LINES);

   always_comb begin
      au_bank   = bank_ff;
      au_colour = item_colour_ff;
      au_line   = LINE_W'(item_row_ff);
      au_byte   = BYTE_W'(item_column_ff >> 3);
      case (state_ff)
         ST_BAR: begin
            au_colour = green_ff;
            au_line   = line_ff;
         end
         ST_SCAN: begin
            au_bank   = ~bank_ff;
            au_colour = 1'b0;
            au_line   = line_ff;
            au_byte   = byte_ff;
         end
         default: begin
         end
      endcase
   end

   lmsb_addr_unit #(
      .PANEL_COLUMNS (PANEL_COLUMNS),
      .PANEL_LINES   (PANEL_LINES),
      .ADDR_W        (ADDR_W),
      .LINE_W        (LINE_W),
      .BYTE_W        (BYTE_W)
   ) u_addr (
      .bank_sel (au_bank),
      .colour   (au_colour),
      .line     (au_line),
      .byte_idx (au_byte),
      .level    (item_level_ff),
      .addr     (au_addr),
      .lit      (au_lit)
   );

   assign rmw_issue  = ((state_ff == ST_PIXEL) && item_valid) || (state_ff == ST_BAR);
   assign rmw_lit    = (state_ff == ST_PIXEL) ? item_on_ff : au_lit;
   assign scan_issue = (state_ff == ST_SCAN) && (!rd_pending_ff || load_out);
   assign line_done  = (byte_ff == BYTE_W'(3));
   assign scan_last  = line_done && (32'(line_ff) < SCAN_GROUPS);
   assign mem_re     = rmw_issue || scan_issue;

   assign mem_we    = (state_ff == ST_CLEAR) || wr_pending_ff;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : wr_addr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? DARK_BYTE :
                      wr_lit_ff ? (rd_red & ~wr_mask_ff) : (rd_red | wr_mask_ff);

   lmsb_frame_mem #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_en     (mem_re),
      .rd_addr_a (au_addr),
      .rd_addr_b (au_addr + ADDR_W'(PLANE_BYTES)),
      .rd_data_a (rd_red),
      .rd_data_b (rd_green)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      bank_in       = bank_ff;
      scan_row_in   = scan_row_ff;
      swap_in       = swap_ff;
      line_in       = line_ff;
      byte_in       = byte_ff;
      green_in      = green_ff;
      wr_pending_in = rmw_issue;
      rd_pending_in = scan_issue ? 1'b1 : (load_out ? 1'b0 : rd_pending_ff);
      rsp_valid_in  = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  OP_PIXEL: begin
                     state_in = ST_PIXEL;
                  end
                  OP_BAR: begin
                     line_in  = '0;
                     green_in = 1'b0;
                     if (32'(req_column) < PANEL_COLUMNS) begin
                        state_in = ST_BAR;
                     end
                  end
                  OP_SWAP: begin
                     swap_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_SCAN;
                     line_in  = LINE_W'(PANEL_LINES - SCAN_GROUPS) + LINE_W'(scan_row_ff);
                     byte_in  = BYTE_W'(LINE_BYTES - 4);
                  end
               endcase
            end
         end
         ST_PIXEL: begin
            state_in = ST_IDLE;
         end
         ST_BAR: begin
            // red rows first, then green rows
            if (!green_ff) begin
               if (line_ff == LINE_W'(RED_LAST)) begin
                  green_in = 1'b1;
                  line_in  = LINE_W'(BAR_GREEN_FIRST);
               end else begin
                  line_in = line_ff + 1'b1;
               end
            end else begin
               line_in = line_ff + 1'b1;
               if (line_ff == LINE_W'(PANEL_LINES - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               if (byte_ff[1:0] == 2'b11) begin
                  if (line_done) begin
                     byte_in = BYTE_W'(LINE_BYTES - 4);
                     line_in = line_ff - LINE_W'(SCAN_GROUPS);
                  end else begin
                     byte_in = byte_ff - BYTE_W'(7);
                  end
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
               if (scan_last) begin
                  state_in = ST_IDLE;
                  if (scan_row_ff == SROW_W'(SCAN_GROUPS - 1)) begin
                     scan_row_in = '0;
                     if (swap_ff) begin
                        bank_in = ~bank_ff;
                        swap_in = 1'b0;
                     end
                  end else begin
                     scan_row_in = scan_row_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         bank_ff       <= 1'b0;
         scan_row_ff   <= '0;
         swap_ff       <= 1'b0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wr_pending_ff <= 1'b0;
         line_ff       <= '0;
         byte_ff       <= '0;
         green_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         bank_ff       <= bank_in;
         scan_row_ff   <= scan_row_in;
         swap_ff       <= swap_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         wr_pending_ff <= wr_pending_in;
         line_ff       <= line_in;
         byte_ff       <= byte_in;
         green_ff      <= green_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_colour_ff <= req_colour;
         item_column_ff <= req_column;
         item_row_ff    <= req_row;
         item_on_ff     <= req_on;
         item_level_ff  <= req_level;
      end
      if (rmw_issue) begin
         wr_addr_ff <= au_addr;
         wr_mask_ff <= 8'(1) << item_column_ff[2:0];
         wr_lit_ff  <= rmw_lit;
      end
      if (scan_issue) begin
         rd_row_ff  <= 4'(scan_row_ff);
         rd_last_ff <= scan_last;
      end
      if (load_out) begin
         rsp_red_ff   <= rd_red;
         rsp_green_ff <= rd_green;
         rsp_row_ff   <= rd_row_ff;
         rsp_last_ff  <= rd_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_green_ff, rsp_red_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
